[sv/fft_pkg.sv]
// fft_pkg: constants, types and twiddle table for the radix-2 FFT unit.
// Used by fft_radix2_unit; no dependencies.
`default_nettype none
package fft_pkg;

  localparam int MaxPointsDef   = 64;
  localparam int TwiddleBitsDef = 16;
  localparam int ValW           = 24;
  localparam int SampleW        = 16;
  localparam int AddrW          = 6;
  localparam int LgW            = 3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FFT,
    ST_EMIT
  } state_t;

  // Butterfly phase within one butterfly
  typedef enum logic [1:0] {
    BF_RD_B,
    BF_RD_A,
    BF_MUL,
    BF_WR
  } bf_phase_t;

  // round(cos(m*pi/32) * 2^23), m = 0..16
  function automatic logic [23:0] quarter_cos(input logic [4:0] m);
    logic [23:0] v;
    begin
      case (m)
        5'd0:  v = 24'd8388608;
        5'd1:  v = 24'd8348215;
        5'd2:  v = 24'd8227423;
        5'd3:  v = 24'd8027397;
        5'd4:  v = 24'd7750063;
        5'd5:  v = 24'd7398092;
        5'd6:  v = 24'd6974873;
        5'd7:  v = 24'd6484482;
        5'd8:  v = 24'd5931642;
        5'd9:  v = 24'd5321677;
        5'd10: v = 24'd4660461;
        5'd11: v = 24'd3954362;
        5'd12: v = 24'd3210181;
        5'd13: v = 24'd2435084;
        5'd14: v = 24'd1636536;
        5'd15: v = 24'd822227;
        default: v = 24'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[sv/fft_radix2_unit.sv]
// fft_radix2_unit: in-place radix-2 DIT FFT, one shared butterfly and a
// work memory with one read and one write port. Depends on fft_pkg.
//
// Channel  Direction  Signals
// in       input      in_valid, in_stall, in_sample_re, in_sample_im
// out      output     out_valid, out_stall, out_bin_re/im, out_bin_index, out_last_bin
// cfg      input      cfg_we, cfg_wdata (log2_size)
//
// Loading takes a sample whenever in_valid is high. After the last sample of a
// frame the butterfly unit runs (N/2)*log2(N) butterflies, each reading b, then a,
// then writing a+bW and a-bW back, bound by the single read port of the work
// memory; then N bins leave at up to one per cycle while out is not stalled.
// Synchronous active-low reset clears control state; memory is not cleared.
// A stall on out holds the current bin; input is stalled outside loading.
`default_nettype none
module fft_radix2_unit #(
  parameter int MAX_POINTS   = fft_pkg::MaxPointsDef,
  parameter int TWIDDLE_BITS = fft_pkg::TwiddleBitsDef
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [fft_pkg::SampleW-1:0] in_sample_re,
  input  wire signed [fft_pkg::SampleW-1:0] in_sample_im,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [fft_pkg::ValW-1:0] out_bin_re,
  output logic signed [fft_pkg::ValW-1:0] out_bin_im,
  output logic [fft_pkg::AddrW-1:0]      out_bin_index,
  output logic                           out_last_bin,
  input  wire                            cfg_we,
  input  wire [fft_pkg::LgW-1:0]         cfg_wdata
);

  localparam int AW    = fft_pkg::AddrW;
  localparam int VW    = fft_pkg::ValW;
  localparam int TW    = TWIDDLE_BITS;
  localparam int SHR   = 24 - TW;
  localparam int MaxLg = (MAX_POINTS >= 64) ? 6 : (MAX_POINTS >= 32) ? 5 :
                         (MAX_POINTS >= 16) ? 4 : (MAX_POINTS >= 8) ? 3 :
                         (MAX_POINTS >= 4) ? 2 : 1;
  localparam int PW    = VW + TW + 1;
  localparam int LgW_C = fft_pkg::LgW;

  // Work memory
  logic [2*VW-1:0] mem [0:(1<<AW)-1];
  logic [2*VW-1:0] rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*VW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Control registers
  fft_pkg::state_t    state_r, state_nxt;
  fft_pkg::bf_phase_t ph_r, ph_nxt;
  logic [LgW_C-1:0]   lg_reg_r;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic [LgW_C-1:0]   stg_r, stg_nxt;
  logic [AW-1:0]      bfi_r, bfi_nxt;
  logic [AW:0]        emit_r, emit_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pidx_r, pidx_nxt;
  logic [AW-1:0]      oidx_r, oidx_nxt;
  logic               olast_r, olast_nxt;
  logic signed [VW-1:0] ore_r, oim_r;
  logic               ocap;

  // Butterfly datapath: product taken from the b read, a held for the difference
  logic signed [VW-1:0] a_re_r, a_im_r;
  logic signed [PW:0]   t_re_r, t_im_r;
  logic signed [VW-1:0] rd_re, rd_im;
  assign rd_re = rd_data_r[2*VW-1:VW];
  assign rd_im = rd_data_r[VW-1:0];

  // Active size
  logic [LgW_C-1:0] lg;
  always_comb begin
    lg = lg_reg_r;
    if (lg == '0) lg = LgW_C'(1);
    if (lg > LgW_C'(6)) lg = LgW_C'(6);
    if (lg > LgW_C'(MaxLg)) lg = LgW_C'(MaxLg);
  end
  logic [AW:0] npts;
  assign npts = (AW+1)'(1) << lg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_reg_r <= LgW_C'(6);
    end else if (cfg_we) begin
      lg_reg_r <= cfg_wdata;
    end
  end

  // Bit reversal of the load index
  logic [AW-1:0] brev;
  always_comb begin
    brev = '0;
    for (int i = 0; i < AW; i++) begin
      if (i < int'(lg)) brev[int'(lg)-1-i] = cnt_r[i];
    end
  end

  // Butterfly addressing: half = 2^(stg), bfi -> group and k
  logic [AW-1:0] half, kk, addr_a, addr_b, tidx;
  always_comb begin
    half   = AW'(1) << stg_r;
    kk     = bfi_r & (half - AW'(1));
    addr_a = ((bfi_r & ~(half - AW'(1))) << 1) | kk;
    addr_b = addr_a | half;
    tidx   = AW'(kk << (3'd5 - stg_r));
  end

  // Twiddle lookup: W = cos - i sin at angle 2*pi*t/64, t in 0..31
  function automatic logic signed [TW:0] red(input logic [23:0] q);
    logic [24:0] v;
    begin
      v = {1'b0, q};
      if (SHR > 0) v = (v + (25'(1) << (SHR > 0 ? SHR - 1 : 0))) >> SHR;
      return $signed({1'b0, v[TW-1:0]});
    end
  endfunction

  logic [4:0] t5;
  logic signed [TW:0] wr, wi;
  always_comb begin
    t5 = tidx[4:0];
    if (t5 <= 5'd16) begin
      wr = red(fft_pkg::quarter_cos(t5));
      wi = -red(fft_pkg::quarter_cos(5'd16 - t5));
    end else begin
      wr = -red(fft_pkg::quarter_cos(5'd0 - t5));
      wi = -red(fft_pkg::quarter_cos(t5 - 5'd16));
    end
  end

  // Complex multiply on the b read, round half up
  logic signed [PW:0] p_re, p_im;
  always_comb begin
    p_re = PW'(rd_re) * wr - PW'(rd_im) * wi + (PW+1)'(1 <<< (TW-2));
    p_im = PW'(rd_re) * wi + PW'(rd_im) * wr + (PW+1)'(1 <<< (TW-2));
  end

  logic signed [VW:0] s_re, s_im, d_re, d_im, t_re, t_im;
  assign t_re = (VW+1)'(t_re_r >>> (TW-1));
  assign t_im = (VW+1)'(t_im_r >>> (TW-1));
  assign s_re = rd_re + t_re;
  assign s_im = rd_im + t_im;
  assign d_re = a_re_r - t_re;
  assign d_im = a_im_r - t_im;

  always_ff @(posedge clk) begin
    case (ph_r)
      fft_pkg::BF_RD_A: begin
        t_re_r <= p_re;
        t_im_r <= p_im;
      end
      fft_pkg::BF_MUL: begin
        a_re_r <= rd_re;
        a_im_r <= rd_im;
      end
      default: ;
    endcase
  end

  assign ocap = !ovalid_r || !out_stall;

  // Control FSM
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    stg_nxt    = stg_r;
    bfi_nxt    = bfi_r;
    emit_nxt   = emit_r;
    ovalid_nxt = ovalid_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    oidx_nxt   = oidx_r;
    olast_nxt  = olast_r;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = brev;
    mem_wdata  = {VW'(in_sample_re), VW'(in_sample_im)};
    mem_raddr  = addr_b;
    case (state_r)
      fft_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mem_we = 1'b1;
          if (cnt_r + 1'b1 == npts) begin
            cnt_nxt   = '0;
            state_nxt = fft_pkg::ST_FFT;
            ph_nxt    = fft_pkg::BF_RD_B;
            stg_nxt   = '0;
            bfi_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      fft_pkg::ST_FFT: begin
        case (ph_r)
          fft_pkg::BF_RD_B: begin
            mem_raddr = addr_b;
            ph_nxt    = fft_pkg::BF_RD_A;
          end
          fft_pkg::BF_RD_A: begin
            mem_raddr = addr_a;
            ph_nxt    = fft_pkg::BF_MUL;
          end
          fft_pkg::BF_MUL: begin
            mem_we    = 1'b1;
            mem_waddr = addr_a;
            mem_wdata = {s_re[VW-1:0], s_im[VW-1:0]};
            ph_nxt    = fft_pkg::BF_WR;
          end
          default: begin
            mem_we    = 1'b1;
            mem_waddr = addr_b;
            mem_wdata = {d_re[VW-1:0], d_im[VW-1:0]};
            ph_nxt    = fft_pkg::BF_RD_B;
            if (bfi_r == AW'((npts >> 1) - 1'b1)) begin
              bfi_nxt = '0;
              if (stg_r + 1'b1 == lg) begin
                state_nxt = fft_pkg::ST_EMIT;
                emit_nxt  = '0;
              end else begin
                stg_nxt = stg_r + 1'b1;
              end
            end else begin
              bfi_nxt = bfi_r + 1'b1;
            end
          end
        endcase
      end
      default: begin
        // Emit: issue a read when the output slot will be free
        mem_raddr = emit_r[AW-1:0];
        if (ocap) begin
          ovalid_nxt = pend_r;
          if (pend_r) begin
            oidx_nxt  = pidx_r;
            olast_nxt = (AW+1)'(pidx_r) == npts - 1'b1;
          end
          if (emit_r != npts) begin
            pend_nxt = 1'b1;
            pidx_nxt = emit_r[AW-1:0];
            emit_nxt = emit_r + 1'b1;
          end else if (!pend_r) begin
            state_nxt = fft_pkg::ST_LOAD;
          end
        end else begin
          pend_nxt  = pend_r;
          mem_raddr = pidx_r;
        end
      end
    endcase
    if (cfg_we) begin
      cnt_nxt = '0;
    end
  end

  // Output payload capture
  always_ff @(posedge clk) begin
    if (state_r == fft_pkg::ST_EMIT && ocap && pend_r) begin
      ore_r <= rd_data_r[2*VW-1:VW];
      oim_r <= rd_data_r[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fft_pkg::ST_LOAD;
      ph_r     <= fft_pkg::BF_RD_B;
      cnt_r    <= '0;
      stg_r    <= '0;
      bfi_r    <= '0;
      emit_r   <= '0;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
      pidx_r   <= '0;
      oidx_r   <= '0;
      olast_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      stg_r    <= stg_nxt;
      bfi_r    <= bfi_nxt;
      emit_r   <= emit_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
      pidx_r   <= pidx_nxt;
      oidx_r   <= oidx_nxt;
      olast_r  <= olast_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_bin_re    = ore_r;
  assign out_bin_im    = oim_r;
  assign out_bin_index = oidx_r;
  assign out_last_bin  = olast_r;

`ifndef SYNTHESIS
  // Input is only taken while loading
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == fft_pkg::ST_LOAD)
    else $error("input open outside load");
  // Results appear only during emit
  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> state_r == fft_pkg::ST_EMIT)
    else $error("result outside emit");
  // Last bin carries the top index of the frame
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> (AW+1)'(out_bin_index) == npts - 1'b1)
    else $error("last bin index mismatch");
`endif

endmodule
`default_nettype wire
